### rtl/core/madt_local_apic_record_walker_unit_assert.svh
// Assertion shorthands for the walker RTL.
// Every macro samples on the rising edge of clk and is masked during rst.
`ifndef MADT_LOCAL_APIC_RECORD_WALKER_UNIT_ASSERT_SVH
`define MADT_LOCAL_APIC_RECORD_WALKER_UNIT_ASSERT_SVH

// A condition that must hold at every edge.
`define MADTLW_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold at the same edge as the antecedent.
`define MADTLW_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define MADTLW_FOLLOWS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/madtlw_pkg.sv
package madtlw_pkg;

  localparam int MAX_CPUS_DEF = 16;

  localparam logic [31:0] WALK_START  = 32'd44;
  localparam logic [31:0] LAST_SHORT  = 32'd43;
  localparam logic [7:0]  ENABLE_MASK = 8'h01;
  localparam logic [7:0]  TYPE_LAPIC  = 8'h00;
  localparam logic [7:0]  LAPIC_MIN   = 8'd8;
  localparam logic [7:0]  RECORD_MIN  = 8'd2;

  typedef enum logic [1:0] {
    KIND_CPU  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic [31:0] table_length;
    logic [31:0] base_address;
    logic [31:0] record_start;
    logic [7:0]  record_type;
    logic [7:0]  record_length;
    logic [7:0]  held_processor_uid;
    logic [7:0]  held_apic_ident;
    logic        walk_stopped;
  } walk_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [7:0]  processor_uid;
    logic [7:0]  apic_ident;
    logic        is_enabled;
    logic        is_bootstrap;
    logic [4:0]  cpus_total;
    logic [31:0] controller_base;
  } result_t;

endpackage

### rtl/core/madtlw_in_if.sv
interface madtlw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       first_byte;

  modport source (output valid, output table_byte, output first_byte, input ready);
  modport sink (input valid, input table_byte, input first_byte, output ready);
endinterface

### rtl/core/madtlw_out_if.sv
interface madtlw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [7:0]  processor_uid;
  logic [7:0]  apic_ident;
  logic        is_enabled;
  logic        is_bootstrap;
  logic [4:0]  cpus_total;
  logic [31:0] controller_base;

  modport source (
    output valid, output kind, output slot, output processor_uid, output apic_ident,
    output is_enabled, output is_bootstrap, output cpus_total, output controller_base,
    input ready
  );
  modport sink (
    input valid, input kind, input slot, input processor_uid, input apic_ident,
    input is_enabled, input is_bootstrap, input cpus_total, input controller_base,
    output ready
  );
endinterface

### rtl/core/madtlw_step.sv
module madtlw_step #(
  parameter int MAX_CPUS = madtlw_pkg::MAX_CPUS_DEF,
  localparam int CW = $clog2(MAX_CPUS + 1)
) (
  input  madtlw_pkg::walk_state_t cur,
  input  logic [CW-1:0]           cpus_cur,
  input  logic [7:0]              table_byte,
  input  logic                    first_byte,
  output madtlw_pkg::walk_state_t nxt,
  output logic [CW-1:0]           cpus_nxt,
  output logic                    emit,
  output madtlw_pkg::result_t     result
);
  import madtlw_pkg::*;

  localparam logic [CW-1:0] CPU_CAP = CW'(MAX_CPUS);

  walk_state_t st;
  logic [CW-1:0] cpus;
  logic [31:0] offs;
  logic [31:0] rec_pos;
  logic [31:0] end_last;
  logic [32:0] rec_end;
  logic [7:0]  rec_len;
  logic        walking;
  logic        bad;
  logic        cpu_hit;
  logic        done;
  logic        en;

  always_comb begin
    // restart on the first byte of a table
    st = cur;
    cpus = cpus_cur;
    if (first_byte) begin
      st = '0;
      st.record_start = WALK_START;
      cpus = '0;
    end

    offs = st.byte_offset;
    rec_pos = offs - st.record_start;
    walking = (offs >= WALK_START) && (st.table_length >= WALK_START);
    rec_len = (rec_pos == 32'd1) ? table_byte : st.record_length;
    rec_end = {1'b0, st.record_start} + {25'd0, table_byte};
    en = |(table_byte & ENABLE_MASK);
    end_last = (st.table_length < WALK_START) ? LAST_SHORT : (st.table_length - 32'd1);

    bad = walking && (rec_pos == 32'd1)
          && ((table_byte < RECORD_MIN) || (rec_end > {1'b0, st.table_length}));
    cpu_hit = walking && (rec_pos == 32'd4) && (st.record_type == TYPE_LAPIC)
              && (st.record_length >= LAPIC_MIN) && (cpus < CPU_CAP);

    nxt = st;
    cpus_nxt = cpus;
    emit = 1'b0;
    done = 1'b0;
    result = '0;

    if (!st.walk_stopped) begin
      nxt.byte_offset = offs + 32'd1;
      if (offs[31:2] == 30'd1) begin
        nxt.table_length[8*offs[1:0] +: 8] = st.table_length[8*offs[1:0] +: 8] | table_byte;
      end
      if (offs[31:2] == 30'd9) begin
        nxt.base_address[8*offs[1:0] +: 8] = st.base_address[8*offs[1:0] +: 8] | table_byte;
      end

      if (walking) begin
        unique case (rec_pos)
          32'd0:   nxt.record_type = table_byte;
          32'd1:   nxt.record_length = table_byte;
          32'd2:   nxt.held_processor_uid = table_byte;
          32'd3:   nxt.held_apic_ident = table_byte;
          default: ;
        endcase
        // advance to the next record on its last byte
        if (!bad && (rec_pos != 32'd0) && ((rec_pos + 32'd1) == {24'd0, rec_len})) begin
          nxt.record_start = st.record_start + {24'd0, rec_len};
        end
      end

      done = !bad && !cpu_hit && (offs >= 32'd7) && (offs == end_last);

      priority if (bad) begin
        emit = 1'b1;
        nxt.walk_stopped = 1'b1;
        result.kind = KIND_BAD;
        result.cpus_total = 5'(cpus);
      end else if (cpu_hit) begin
        emit = 1'b1;
        cpus_nxt = cpus + CW'(1);
        result.kind = KIND_CPU;
        result.slot = 4'(cpus);
        result.processor_uid = st.held_processor_uid;
        result.apic_ident = st.held_apic_ident;
        result.is_enabled = en;
        result.is_bootstrap = en && (cpus == '0);
      end else if (done) begin
        emit = 1'b1;
        nxt.walk_stopped = 1'b1;
        result.kind = KIND_DONE;
        result.cpus_total = 5'(cpus);
      end
      result.controller_base = nxt.base_address;
    end
  end

endmodule

### rtl/core/madt_local_apic_record_walker_unit.sv
// Channel | Dir | Carries
// --------+-----+---------------------------------------------------------
// feed    | in  | table_byte, first_byte: one table byte per request
// report  | out | kind, slot, processor_uid, apic_ident, is_enabled,
//         |     | is_bootstrap, cpus_total, controller_base
//
// One byte per cycle sustained while report is not stalled; a byte is held in the input
// register, then the parse logic writes its result into the result register.
// The throughput is set by the single parse step between those two registers.
// rst clears the parse state; bytes are ignored until one arrives with first_byte set.
// A stalled report holds the result and the byte in the input register, so
// feed.ready drops when both registers are full and report is not taken.
`include "madt_local_apic_record_walker_unit_assert.svh"

module madt_local_apic_record_walker_unit #(
  parameter int MAX_CPUS = madtlw_pkg::MAX_CPUS_DEF
) (
  input logic         clk,
  input logic         rst,
  madtlw_in_if.sink   feed,
  madtlw_out_if.source report
);
  import madtlw_pkg::*;

  localparam int CW = $clog2(MAX_CPUS + 1);
  localparam walk_state_t ST_RESET = '{
    record_start: WALK_START,
    walk_stopped: 1'b1,
    default: '0
  };

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_first;
  walk_state_t   st;
  walk_state_t   st_next;
  logic [CW-1:0] cpus_added;
  logic [CW-1:0] cpus_added_next;
  logic          res_valid;
  result_t       res;
  result_t       res_next;
  logic          emit;
  logic          advance;
  logic          end_emit;
  logic          cpu_emit;
  logic          pipe_full;

  assign advance = s1_valid && (!res_valid || report.ready);
  assign feed.ready = !s1_valid || advance;

  madtlw_step #(.MAX_CPUS(MAX_CPUS)) u_step (
    .cur        (st),
    .cpus_cur   (cpus_added),
    .table_byte (s1_byte),
    .first_byte (s1_first),
    .nxt        (st_next),
    .cpus_nxt   (cpus_added_next),
    .emit       (emit),
    .result     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed.valid && feed.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.valid && feed.ready) begin
      s1_byte <= feed.table_byte;
      s1_first <= feed.first_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
      cpus_added <= '0;
    end else if (advance) begin
      st <= st_next;
      cpus_added <= cpus_added_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= emit;
    end else if (report.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= res_next;
    end
  end

  assign report.valid = res_valid;
  assign report.kind = res.kind;
  assign report.slot = res.slot;
  assign report.processor_uid = res.processor_uid;
  assign report.apic_ident = res.apic_ident;
  assign report.is_enabled = res.is_enabled;
  assign report.is_bootstrap = res.is_bootstrap;
  assign report.cpus_total = res.cpus_total;
  assign report.controller_base = res.controller_base;

  assign end_emit = advance && emit && (res_next.kind != KIND_CPU);
  assign cpu_emit = advance && emit && (res_next.kind == KIND_CPU);
  assign pipe_full = s1_valid && res_valid && !report.ready;

  `MADTLW_HOLDS(a_cpu_cap, cpus_added <= CW'(MAX_CPUS), "cpu count above capacity")
  `MADTLW_FOLLOWS(a_end_stops, end_emit, st.walk_stopped, "walk still running after end result")
  `MADTLW_FOLLOWS(a_cpu_count, cpu_emit, cpus_added == CW'($past(cpus_added) + 1'b1), "cpu not counted")
  `MADTLW_IMPLIES(a_stall_src, !feed.ready, pipe_full, "input stalled without full pipe")

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import madtlw_pkg::*;

  localparam int CPU_SLOTS = MAX_CPUS_DEF;
  localparam int RANDOM_BYTES = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD_AT = 600;
  localparam int LONG_HOLD_LEN = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [7:0] TYPE_IO_APIC = 8'h01;
  localparam logic [7:0] TYPE_OEM_TOP = 8'hFF;

  typedef bit [7:0] byte_q_t[$];

  class cpu_entry_scoreboard;
    bit [31:0] offset, table_len, base, rec_start;
    bit [7:0] rec_type, rec_len, uid, apic_id;
    bit [4:0] cpus;
    bit halted;
    result_t results_due[$];
    int errors;

    function new();
      restart();
      halted = 1'b1;
      errors = 0;
    endfunction

    function void restart();
      offset = 0;
      table_len = 0;
      base = 0;
      rec_start = WALK_START;
      rec_type = 0;
      rec_len = 0;
      uid = 0;
      apic_id = 0;
      cpus = 0;
    endfunction

    function result_t make_result(kind_t k, bit [3:0] slot, bit [7:0] puid, bit [7:0] apic,
                                  bit en, bit bsp, bit [4:0] total);
      result_t r;
      r.kind = k;
      r.slot = slot;
      r.processor_uid = puid;
      r.apic_ident = apic;
      r.is_enabled = en;
      r.is_bootstrap = bsp;
      r.cpus_total = total;
      r.controller_base = base;
      return r;
    endfunction

    // Advance the parse by one accepted byte and queue the result it causes.
    function void note_request(bit [7:0] b, bit first);
      bit [31:0] o, d, last;
      bit emitted, en;
      emitted = 1'b0;
      if (first) begin
        restart();
        halted = 1'b0;
      end
      if (halted) return;
      o = offset;
      offset = o + 1;
      if (o >= 4 && o <= 7) table_len |= 32'(b) << (8 * (o - 4));
      if (o >= 36 && o <= 39) base |= 32'(b) << (8 * (o - 36));
      if (o >= WALK_START && table_len >= WALK_START) begin
        d = o - rec_start;
        if (d == 0) begin
          rec_type = b;
        end else if (d == 1) begin
          rec_len = b;
          if (b < RECORD_MIN || 33'(rec_start) + 33'(b) > 33'(table_len)) begin
            results_due.push_back(make_result(KIND_BAD, 0, 0, 0, 0, 0, cpus));
            halted = 1'b1;
            return;
          end
        end else if (d == 2) begin
          uid = b;
        end else if (d == 3) begin
          apic_id = b;
        end else if (d == 4 && rec_type == TYPE_LAPIC && rec_len >= LAPIC_MIN) begin
          if (cpus < CPU_SLOTS) begin
            en = |(b & ENABLE_MASK);
            results_due.push_back(make_result(KIND_CPU, cpus[3:0], uid, apic_id, en,
                                              en && cpus == 0, 0));
            cpus++;
            emitted = 1'b1;
          end
        end
        if (d >= 1 && d + 1 == 32'(rec_len)) rec_start += rec_len;
      end
      last = (table_len < WALK_START) ? LAST_SHORT : table_len - 1;
      if (o >= 7 && o == last && !emitted) begin
        results_due.push_back(make_result(KIND_DONE, 0, 0, 0, 0, 0, cpus));
        halted = 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, seen);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got kind %0d slot %0d total %0d",
                 $time, got.kind, got.slot, got.cpus_total);
        return;
      end
      want = results_due.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("slot", want.slot, got.slot);
      compare_field("processor_uid", want.processor_uid, got.processor_uid);
      compare_field("apic_ident", want.apic_ident, got.apic_ident);
      compare_field("is_enabled", want.is_enabled, got.is_enabled);
      compare_field("is_bootstrap", want.is_bootstrap, got.is_bootstrap);
      compare_field("cpus_total", want.cpus_total, got.cpus_total);
      compare_field("controller_base", want.controller_base, got.controller_base);
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic clk, rst;
  madtlw_in_if feed_if();
  madtlw_out_if report_if();
  cpu_entry_scoreboard sb;
  int bytes_sent;
  int idle_cycles = 0;

  madt_local_apic_record_walker_unit #(.MAX_CPUS(CPU_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .feed(feed_if),
    .report(report_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put_header(ref byte_q_t q, input bit [31:0] len,
                                     input bit [31:0] base_addr);
    for (int i = 0; i < WALK_START; i++) begin
      if (i >= 4 && i <= 7) q.push_back(len[8 * (i - 4) +: 8]);
      else if (i >= 36 && i <= 39) q.push_back(base_addr[8 * (i - 36) +: 8]);
      else q.push_back(8'($urandom));
    end
  endfunction

  // Lengths below two still carry their type and length bytes.
  function automatic void put_record(ref byte_q_t q, input bit [7:0] typ, input bit [7:0] len,
                                     input bit [7:0] puid, input bit [7:0] apic,
                                     input bit [7:0] flags);
    int n;
    n = (len < RECORD_MIN) ? 2 : len;
    for (int i = 0; i < n; i++) begin
      case (i)
        0: q.push_back(typ);
        1: q.push_back(len);
        2: q.push_back(puid);
        3: q.push_back(apic);
        4: q.push_back(flags);
        default: q.push_back(8'($urandom));
      endcase
    end
  endfunction

  function automatic void put_random_record(ref byte_q_t q);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      put_record(q, TYPE_LAPIC, ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 14)) : LAPIC_MIN,
                 8'($urandom), 8'($urandom), 8'($urandom));
    else if (pick < 70)
      put_record(q, TYPE_LAPIC, 8'($urandom_range(2, 7)), 8'($urandom), 8'($urandom),
                 8'($urandom));
    else if (pick < 98)
      put_record(q, 8'($urandom_range(1, 255)), 8'($urandom_range(2, 16)), 8'($urandom),
                 8'($urandom), 8'($urandom));
    else
      put_record(q, 8'($urandom), 8'($urandom_range(200, 255)), 8'($urandom), 8'($urandom),
                 8'($urandom));
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input bit [7:0] b, input bit first, input bit steady);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      feed_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed_if.valid <= 1'b1;
    feed_if.table_byte <= b;
    feed_if.first_byte <= first;
    do @(posedge clk); while (!feed_if.ready);
    sb.note_request(b, first);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_table(input byte_q_t body, input bit [31:0] len, input bit [31:0] base_addr,
                            input bit steady, input int keep);
    byte_q_t q;
    put_header(q, len, base_addr);
    q = {q, body};
    if (keep > 0 && keep < q.size()) q = q[0:keep - 1];
    foreach (q[i]) send_byte(q[i], i == 0, steady);
  endtask

  task automatic random_table();
    byte_q_t body;
    bit [31:0] len;
    int shape, nrec, room, rl, keep;
    shape = $urandom_range(0, 99);
    keep = 0;
    nrec = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 6);
    for (int i = 0; i < nrec; i++) put_random_record(body);
    len = WALK_START + body.size();
    if (shape < 60) begin
      if ($urandom_range(0, 7) == 0) begin
        body.push_back(8'($urandom));
        len++;
      end
    end else if (shape < 66) begin
      len += $urandom_range(2, 20);
      put_record(body, 8'($urandom), 8'($urandom_range(0, 1)), 0, 0, 0);
    end else if (shape < 74) begin
      // record that runs past the table end
      room = $urandom_range(0, 30);
      rl = $urandom_range((room < 2) ? 2 : room + 1, (room + 40 > 255) ? 255 : room + 40);
      len += room;
      body.push_back(TYPE_LAPIC);
      body.push_back(8'(rl));
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
    end else if (shape < 84) begin
      len = $urandom_range(0, 43);
    end else if (shape < 92) begin
      keep = $urandom_range(1, WALK_START + body.size() - 1);
    end else begin
      len = $urandom | 32'h0001_0000;
    end
    if (shape < 84 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
    send_table(body, len, ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : 32'($urandom),
               $urandom_range(0, 4) == 0, keep);
  endtask

  task automatic settle();
    feed_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    byte_q_t body;
    int stop_at, tables;
    rst = 1'b1;
    feed_if.valid = 1'b0;
    feed_if.table_byte = 8'h00;
    feed_if.first_byte = 1'b0;
    bytes_sent = 0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no table started yet: drop these
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);

    // short tables, the first with bytes after the end that must be dropped
    body = {8'h00, 8'hFF};
    send_table(body, 32'd0, 32'hFFFF_FFFF, 1'b0, 0);
    body.delete();
    send_table(body, LAST_SHORT, 32'd0, 1'b1, 0);
    send_table(body, WALK_START, 32'h1234_5678, 1'b0, 0);

    // disabled first cpu, skipped records, trailing single byte
    put_record(body, TYPE_LAPIC, LAPIC_MIN, 8'h00, 8'h00, 8'hFE);
    put_record(body, TYPE_LAPIC, LAPIC_MIN, 8'hFF, 8'hFF, 8'hFF);
    put_record(body, TYPE_LAPIC, 8'd7, 8'h11, 8'h22, ENABLE_MASK);
    put_record(body, TYPE_IO_APIC, RECORD_MIN, 8'h00, 8'h00, 8'h00);
    put_record(body, TYPE_OEM_TOP, 8'd12, 8'h33, 8'h44, 8'h55);
    body.push_back(8'h5A);
    send_table(body, WALK_START + body.size(), 32'h0, 1'b0, 0);

    // enabled first cpu is the bootstrap one; longest record
    body.delete();
    put_record(body, TYPE_LAPIC, LAPIC_MIN, 8'h07, 8'h09, ENABLE_MASK);
    put_record(body, TYPE_LAPIC, 8'hFF, 8'h01, 8'h02, 8'h03);
    send_table(body, WALK_START + body.size(), 32'hFEE0_0000, 1'b1, 0);

    // record lengths zero and one stop the walk
    body.delete();
    put_record(body, TYPE_LAPIC, 8'd0, 8'h00, 8'h00, 8'h00);
    send_table(body, WALK_START + 10, 32'hA5A5_5A5A, 1'b0, 0);
    body.delete();
    put_record(body, TYPE_IO_APIC, LAPIC_MIN, 8'h00, 8'h00, 8'h00);
    put_record(body, TYPE_LAPIC, 8'd1, 8'h00, 8'h00, 8'h00);
    send_table(body, WALK_START + 20, 32'h5A5A_A5A5, 1'b0, 0);

    // overrun detected on the length byte, which is also the last byte
    body.delete();
    put_record(body, TYPE_LAPIC, 8'd3, 8'h00, 8'h00, 8'h00);
    send_table(body, WALK_START + 2, 32'h0000_0001, 1'b0, 0);

    // more cpus than the list holds
    body.delete();
    for (int i = 0; i < CPU_SLOTS + 2; i++)
      put_record(body, TYPE_LAPIC, LAPIC_MIN, 8'(i), 8'(i + 1), 8'($urandom));
    send_table(body, WALK_START + body.size(), 32'h8000_0000, 1'b0, 0);

    // cut off mid-walk; next table restarts the parse
    body.delete();
    repeat (3) put_record(body, TYPE_LAPIC, LAPIC_MIN, 8'($urandom), 8'($urandom), 8'($urandom));
    send_table(body, 32'hFFFF_FFFF, 32'h0, 1'b0, 60);

    stop_at = bytes_sent + RANDOM_BYTES;
    tables = 0;
    while (bytes_sent < stop_at) begin
      if (tables == 2) settle();
      random_table();
      tables++;
    end

    settle();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Result side: random back-pressure, one long hold, quiet windows with none.
  initial begin
    int cyc, hold;
    bit long_done;
    cyc = 0;
    hold = 0;
    long_done = 1'b0;
    report_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      cyc++;
      // hold off while a result waits and the sender keeps offering bytes
      if (!long_done && cyc >= LONG_HOLD_AT && report_if.valid && feed_if.valid) begin
        hold = LONG_HOLD_LEN;
        long_done = 1'b1;
      end else if (hold == 0 && (cyc / 128) % 4 != 0 && $urandom_range(0, 99) < 35) begin
        hold = gap_len();
      end
      if (hold > 0) begin
        report_if.ready <= 1'b0;
        hold--;
      end else begin
        report_if.ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && report_if.valid && report_if.ready) begin
      got.kind = kind_t'(report_if.kind);
      got.slot = report_if.slot;
      got.processor_uid = report_if.processor_uid;
      got.apic_ident = report_if.apic_ident;
      got.is_enabled = report_if.is_enabled;
      got.is_bootstrap = report_if.is_bootstrap;
      got.cpus_total = report_if.cpus_total;
      got.controller_base = report_if.controller_base;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (feed_if.valid && feed_if.ready) || (report_if.valid && report_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/madtlw_pkg.sv
rtl/core/madtlw_in_if.sv
rtl/core/madtlw_out_if.sv
rtl/core/madtlw_step.sv
rtl/core/madt_local_apic_record_walker_unit.sv
test/testbench.sv
